// ----- src/wfd_pkg.sv -----
`default_nettype none

package wfd_pkg;

    localparam int ID_W    = 11;
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 32;
    localparam int SPD_W   = 16;
    localparam int RPM_W   = 15;
    localparam int CLASS_W = 3;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [BYTE_W-1:0] KIND_HEARTBEAT = 8'hFE;
    localparam logic [BYTE_W-1:0] KIND_STATUS    = 8'hDB;
    localparam logic [BYTE_W-1:0] IDX_POSITION   = 8'h20;
    localparam logic [BYTE_W-1:0] IDX_SPEED      = 8'h21;
    localparam logic [BYTE_W-1:0] IDX_VOLTAGE    = 8'hE1;

    // speed scale is 3000/8192: multiply, then shift with rounding toward zero
    localparam int SPEED_MUL   = 3000;
    localparam int SPEED_SHIFT = 13;

    localparam logic [ID_W-1:0]   LEFT_ID_RESET  = 11'd1;
    localparam logic [ID_W-1:0]   RIGHT_ID_RESET = 11'd2;
    localparam logic [BYTE_W-1:0] BATTERY_RESET  = 8'd42;

    localparam logic REG_LEFT_ID  = 1'b0;
    localparam logic REG_RIGHT_ID = 1'b1;

    localparam logic [CLASS_W-1:0] MOTION_FORWARD    = 3'd0;
    localparam logic [CLASS_W-1:0] MOTION_SPIN_RIGHT = 3'd1;
    localparam logic [CLASS_W-1:0] MOTION_SPIN_LEFT  = 3'd2;
    localparam logic [CLASS_W-1:0] MOTION_BACKWARD   = 3'd3;
    localparam logic [CLASS_W-1:0] MOTION_STOPPED    = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]   frame_id;
        logic [BYTE_W-1:0] kind_byte;
        logic [BYTE_W-1:0] index_byte;
        logic [BYTE_W-1:0] payload_b4;
        logic [BYTE_W-1:0] payload_b5;
        logic [BYTE_W-1:0] payload_b6;
        logic [BYTE_W-1:0] payload_b7;
    } frame_t;

    typedef struct packed {
        logic left_pos;
        logic right_pos;
        logic left_rpm;
        logic right_rpm;
        logic battery;
    } upd_t;

    function automatic logic [CLASS_W-1:0] motion_of(
        input logic signed [RPM_W-1:0] l,
        input logic signed [RPM_W-1:0] r
    );
        logic [CLASS_W-1:0] m;
        if (l > 0 && r > 0)
        begin
            m = MOTION_FORWARD;
        end
        else if (l >= 0 && r < 0)
        begin
            m = MOTION_SPIN_RIGHT;
        end
        else if (l < 0 && r >= 0)
        begin
            m = MOTION_SPIN_LEFT;
        end
        else if (l < 0 && r < 0)
        begin
            m = MOTION_BACKWARD;
        end
        else
        begin
            m = MOTION_STOPPED;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- src/wheel_feedback_frame_decoder.sv -----
// Wheel feedback frame decoder.
// Input channel (in_valid/in_ready) takes the decoded bytes of one received CAN
// frame per transaction. Output channel (out_valid/out_ready) returns one result
// per frame: both stored positions, both scaled speeds, the battery byte and the
// drive direction class, all as they stand after that frame was applied.
// The APB port holds the left and right node identifiers (offsets 0x0 and 0x4);
// write them only while no frame is in flight.
// A taken frame is captured in the input register and applied into the stored
// feedback registers once the result slot is free, where its result appears.
// Throughput: one frame per cycle unless out_ready stalls; the stored feedback
// registers double as the result register; the update logic works in one pass.
// Reset clears positions and speeds, sets battery to 42, motion class to
// stopped and the node ids to 1 and 2; no result is pending after reset.
// When the receiver stalls, the result holds and one more frame waits in the
// input register; in_ready drops only when both are occupied.
`default_nettype none

module wheel_feedback_frame_decoder (
    input  wire  logic                                clk,
    input  wire  logic                                rst_n,

    input  wire  logic                                psel,
    input  wire  logic                                penable,
    input  wire  logic                                pwrite,
    input  wire  logic [wfd_pkg::ADDR_W-1:0]          paddr,
    input  wire  logic [wfd_pkg::DATA_W-1:0]          pwdata,
    output logic [wfd_pkg::DATA_W-1:0]                prdata,
    output logic                                      pready,

    input  wire  logic                                in_valid,
    output logic                                      in_ready,
    input  wire  logic [wfd_pkg::ID_W-1:0]            frame_id,
    input  wire  logic [wfd_pkg::BYTE_W-1:0]          kind_byte,
    input  wire  logic [wfd_pkg::BYTE_W-1:0]          index_byte,
    input  wire  logic [wfd_pkg::BYTE_W-1:0]          payload_b4,
    input  wire  logic [wfd_pkg::BYTE_W-1:0]          payload_b5,
    input  wire  logic [wfd_pkg::BYTE_W-1:0]          payload_b6,
    input  wire  logic [wfd_pkg::BYTE_W-1:0]          payload_b7,

    output logic                                      out_valid,
    input  wire  logic                                out_ready,
    output logic signed [wfd_pkg::POS_W-1:0]          left_pos,
    output logic signed [wfd_pkg::POS_W-1:0]          right_pos,
    output logic signed [wfd_pkg::RPM_W-1:0]          left_rpm,
    output logic signed [wfd_pkg::RPM_W-1:0]          right_rpm,
    output logic [wfd_pkg::BYTE_W-1:0]                battery_level,
    output logic [wfd_pkg::CLASS_W-1:0]               motion_class
);

    logic [wfd_pkg::ID_W-1:0] left_id_reg;
    logic [wfd_pkg::ID_W-1:0] right_id_reg;
    logic                     cfg_write;
    logic                     cfg_sel;

    wfd_pkg::frame_t frame_reg;
    logic            frame_valid_reg;
    logic            out_valid_reg;
    logic            in_fire;
    logic            advance;
    wfd_pkg::upd_t   upd;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_id_reg  <= wfd_pkg::LEFT_ID_RESET;
            right_id_reg <= wfd_pkg::RIGHT_ID_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                wfd_pkg::REG_LEFT_ID:  left_id_reg  <= pwdata[wfd_pkg::ID_W-1:0];
                wfd_pkg::REG_RIGHT_ID: right_id_reg <= pwdata[wfd_pkg::ID_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            wfd_pkg::REG_LEFT_ID:  prdata = wfd_pkg::DATA_W'(left_id_reg);
            wfd_pkg::REG_RIGHT_ID: prdata = wfd_pkg::DATA_W'(right_id_reg);
            default:               prdata = '0;
        endcase
    end

    // input register, then apply into the result registers
    assign advance  = frame_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !frame_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                frame_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                frame_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            frame_reg.frame_id   <= frame_id;
            frame_reg.kind_byte  <= kind_byte;
            frame_reg.index_byte <= index_byte;
            frame_reg.payload_b4 <= payload_b4;
            frame_reg.payload_b5 <= payload_b5;
            frame_reg.payload_b6 <= payload_b6;
            frame_reg.payload_b7 <= payload_b7;
        end
    end

    wfd_frame_match u_match (
        .frame         (frame_reg),
        .left_node_id  (left_id_reg),
        .right_node_id (right_id_reg),
        .upd           (upd)
    );

    wfd_feedback_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance),
        .frame         (frame_reg),
        .upd           (upd),
        .left_pos      (left_pos),
        .right_pos     (right_pos),
        .left_rpm      (left_rpm),
        .right_rpm     (right_rpm),
        .battery_level (battery_level),
        .motion_class  (motion_class)
    );

    assign out_valid = out_valid_reg;

    // an empty result slot never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input blocked while result slot is empty");

    // stored feedback changes only when a frame is applied
    a_hold_without_load: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(left_pos) && $stable(right_pos) && $stable(left_rpm)
                     && $stable(right_rpm) && $stable(battery_level))
        else $error("feedback changed without a frame");

    // direction class agrees with the reported speeds
    a_motion_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> motion_class == wfd_pkg::motion_of(left_rpm, right_rpm))
        else $error("motion class disagrees with speeds");

endmodule

`default_nettype wire

// ----- src/wfd_frame_match.sv -----
`default_nettype none

module wfd_frame_match (
    input  wire  wfd_pkg::frame_t            frame,
    input  wire  logic [wfd_pkg::ID_W-1:0]   left_node_id,
    input  wire  logic [wfd_pkg::ID_W-1:0]   right_node_id,
    output wfd_pkg::upd_t                    upd
);

    logic is_left;
    logic is_right;
    logic heartbeat;

    assign is_left   = (frame.frame_id == left_node_id);
    assign is_right  = (frame.frame_id == right_node_id);
    assign heartbeat = (frame.kind_byte == wfd_pkg::KIND_HEARTBEAT);

    // equal node ids let one heartbeat update both sides
    assign upd.left_pos  = is_left  && heartbeat && (frame.index_byte == wfd_pkg::IDX_POSITION);
    assign upd.left_rpm  = is_left  && heartbeat && (frame.index_byte == wfd_pkg::IDX_SPEED);
    assign upd.right_pos = is_right && heartbeat && (frame.index_byte == wfd_pkg::IDX_POSITION);
    assign upd.right_rpm = is_right && heartbeat && (frame.index_byte == wfd_pkg::IDX_SPEED);
    assign upd.battery   = is_right && (frame.kind_byte == wfd_pkg::KIND_STATUS)
                           && (frame.index_byte == wfd_pkg::IDX_VOLTAGE);

endmodule

`default_nettype wire

// ----- src/wfd_speed_scale.sv -----
`default_nettype none

module wfd_speed_scale (
    input  wire  logic [wfd_pkg::SPD_W-1:0]        raw,
    output logic signed [wfd_pkg::RPM_W-1:0]       rpm
);

    localparam int PROD_W = wfd_pkg::SPD_W + 13;

    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] biased;

    assign prod = PROD_W'($signed(raw)) * PROD_W'(wfd_pkg::SPEED_MUL);

    // bias negative products so the shift truncates toward zero
    assign biased = prod[PROD_W-1]
                    ? prod + PROD_W'((1 << wfd_pkg::SPEED_SHIFT) - 1)
                    : prod;

    assign rpm = biased[wfd_pkg::SPEED_SHIFT +: wfd_pkg::RPM_W];

endmodule

`default_nettype wire

// ----- src/wfd_feedback_regs.sv -----
`default_nettype none

module wfd_feedback_regs (
    input  wire  logic                                clk,
    input  wire  logic                                rst_n,
    input  wire  logic                                load,
    input  wire  wfd_pkg::frame_t                     frame,
    input  wire  wfd_pkg::upd_t                       upd,
    output logic signed [wfd_pkg::POS_W-1:0]          left_pos,
    output logic signed [wfd_pkg::POS_W-1:0]          right_pos,
    output logic signed [wfd_pkg::RPM_W-1:0]          left_rpm,
    output logic signed [wfd_pkg::RPM_W-1:0]          right_rpm,
    output logic [wfd_pkg::BYTE_W-1:0]                battery_level,
    output logic [wfd_pkg::CLASS_W-1:0]               motion_class
);

    logic [wfd_pkg::POS_W-1:0]          pos_raw;
    logic [wfd_pkg::SPD_W-1:0]          spd_raw;
    logic [wfd_pkg::SPD_W-1:0]          spd_neg;
    logic signed [wfd_pkg::RPM_W-1:0]   left_scaled;
    logic signed [wfd_pkg::RPM_W-1:0]   right_scaled;

    logic [wfd_pkg::POS_W-1:0]          left_pos_reg,  left_pos_next;
    logic [wfd_pkg::POS_W-1:0]          right_pos_reg, right_pos_next;
    logic signed [wfd_pkg::RPM_W-1:0]   left_rpm_reg,  left_rpm_next;
    logic signed [wfd_pkg::RPM_W-1:0]   right_rpm_reg, right_rpm_next;
    logic [wfd_pkg::BYTE_W-1:0]         battery_reg,   battery_next;
    logic [wfd_pkg::CLASS_W-1:0]        motion_reg,    motion_next;

    assign pos_raw = {frame.payload_b4, frame.payload_b5, frame.payload_b6, frame.payload_b7};
    assign spd_raw = {frame.payload_b6, frame.payload_b7};
    assign spd_neg = wfd_pkg::SPD_W'(0) - spd_raw;

    wfd_speed_scale u_scale_left (
        .raw (spd_raw),
        .rpm (left_scaled)
    );

    wfd_speed_scale u_scale_right (
        .raw (spd_neg),
        .rpm (right_scaled)
    );

    always_comb
    begin
        left_pos_next  = upd.left_pos  ? pos_raw : left_pos_reg;
        right_pos_next = upd.right_pos ? (wfd_pkg::POS_W'(0) - pos_raw) : right_pos_reg;
        left_rpm_next  = upd.left_rpm  ? left_scaled  : left_rpm_reg;
        right_rpm_next = upd.right_rpm ? right_scaled : right_rpm_reg;
        battery_next   = upd.battery   ? frame.payload_b7 : battery_reg;
        motion_next    = wfd_pkg::motion_of(left_rpm_next, right_rpm_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_pos_reg  <= '0;
            right_pos_reg <= '0;
            left_rpm_reg  <= '0;
            right_rpm_reg <= '0;
            battery_reg   <= wfd_pkg::BATTERY_RESET;
            motion_reg    <= wfd_pkg::MOTION_STOPPED;
        end
        else if (load)
        begin
            left_pos_reg  <= left_pos_next;
            right_pos_reg <= right_pos_next;
            left_rpm_reg  <= left_rpm_next;
            right_rpm_reg <= right_rpm_next;
            battery_reg   <= battery_next;
            motion_reg    <= motion_next;
        end
    end

    assign left_pos      = $signed(left_pos_reg);
    assign right_pos     = $signed(right_pos_reg);
    assign left_rpm      = left_rpm_reg;
    assign right_rpm     = right_rpm_reg;
    assign battery_level = battery_reg;
    assign motion_class  = motion_reg;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none

module testbench;

    import wfd_pkg::*;

    localparam int IDLE_PCT = 13;
    localparam logic [ADDR_W-1:0] ADDR_LEFT_ID  = {REG_LEFT_ID, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_RIGHT_ID = {REG_RIGHT_ID, 2'b00};

    typedef struct packed {
        logic signed [POS_W-1:0] left_pos;
        logic signed [POS_W-1:0] right_pos;
        logic signed [RPM_W-1:0] left_rpm;
        logic signed [RPM_W-1:0] right_rpm;
        logic [BYTE_W-1:0]       battery;
        logic [CLASS_W-1:0]      motion;
    } feedback_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [ID_W-1:0]   frame_id = '0;
    logic [BYTE_W-1:0] kind_byte = '0;
    logic [BYTE_W-1:0] index_byte = '0;
    logic [BYTE_W-1:0] payload_b4 = '0;
    logic [BYTE_W-1:0] payload_b5 = '0;
    logic [BYTE_W-1:0] payload_b6 = '0;
    logic [BYTE_W-1:0] payload_b7 = '0;

    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [POS_W-1:0]    left_pos;
    logic signed [POS_W-1:0]    right_pos;
    logic signed [RPM_W-1:0]    left_rpm;
    logic signed [RPM_W-1:0]    right_rpm;
    logic [BYTE_W-1:0]          battery_level;
    logic [CLASS_W-1:0]         motion_class;

    // decoder model state and its copy of the node ids
    logic [ID_W-1:0] left_node;
    logic [ID_W-1:0] right_node;
    feedback_t       stored;

    frame_t    frame_q[$];
    feedback_t feedback_q[$];
    frame_t    in_flight;
    logic      steady = 1'b0;
    int        n_accepted = 0;
    int        n_results = 0;
    int        n_errors = 0;
    int        n_settings = 1;
    int        class_seen[5] = '{0, 0, 0, 0, 0};

    wheel_feedback_frame_decoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .frame_id      (frame_id),
        .kind_byte     (kind_byte),
        .index_byte    (index_byte),
        .payload_b4    (payload_b4),
        .payload_b5    (payload_b5),
        .payload_b6    (payload_b6),
        .payload_b7    (payload_b7),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .left_pos      (left_pos),
        .right_pos     (right_pos),
        .left_rpm      (left_rpm),
        .right_rpm     (right_rpm),
        .battery_level (battery_level),
        .motion_class  (motion_class)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_error(input string msg);
        n_errors++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // speed * 3000/8192, truncated toward zero
    function automatic logic signed [RPM_W-1:0] scale_rpm(input logic [SPD_W-1:0] raw);
        int s;
        s = int'($signed(raw));
        return RPM_W'((s * SPEED_MUL) / (1 << SPEED_SHIFT));
    endfunction

    function automatic logic [CLASS_W-1:0] classify(
        input logic signed [RPM_W-1:0] l,
        input logic signed [RPM_W-1:0] r
    );
        if (l < 0)
        begin
            return (r < 0) ? MOTION_BACKWARD : MOTION_SPIN_LEFT;
        end
        if (r < 0)
        begin
            return MOTION_SPIN_RIGHT;
        end
        return (l > 0 && r > 0) ? MOTION_FORWARD : MOTION_STOPPED;
    endfunction

    function automatic feedback_t decode_frame(input frame_t f);
        logic [POS_W-1:0] pos;
        logic [SPD_W-1:0] spd;
        logic [SPD_W-1:0] neg_spd;
        pos = {f.payload_b4, f.payload_b5, f.payload_b6, f.payload_b7};
        spd = {f.payload_b6, f.payload_b7};
        neg_spd = -spd;
        if (f.kind_byte == KIND_HEARTBEAT)
        begin
            // equal node ids update both sides
            if (f.frame_id == left_node)
            begin
                if (f.index_byte == IDX_POSITION)
                    stored.left_pos = pos;
                else if (f.index_byte == IDX_SPEED)
                    stored.left_rpm = scale_rpm(spd);
            end
            if (f.frame_id == right_node)
            begin
                if (f.index_byte == IDX_POSITION)
                    stored.right_pos = -pos;
                else if (f.index_byte == IDX_SPEED)
                    stored.right_rpm = scale_rpm(neg_spd);
            end
        end
        else if (f.kind_byte == KIND_STATUS && f.frame_id == right_node &&
                 f.index_byte == IDX_VOLTAGE)
        begin
            stored.battery = f.payload_b7;
        end
        stored.motion = classify(stored.left_rpm, stored.right_rpm);
        return stored;
    endfunction

    // driver: hand frames from the pending queue to the input channel
    always @(posedge clk)
    begin
        frame_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                feedback_q.push_back(decode_frame(in_flight));
                n_accepted++;
            end
            steady <= (n_accepted >= 300 && n_accepted < 550);
            if (!in_valid || in_ready)
            begin
                if (frame_q.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = frame_q.pop_front();
                    in_flight = nxt;
                    in_valid   <= 1'b1;
                    frame_id   <= nxt.frame_id;
                    kind_byte  <= nxt.kind_byte;
                    index_byte <= nxt.index_byte;
                    payload_b4 <= nxt.payload_b4;
                    payload_b5 <= nxt.payload_b5;
                    payload_b6 <= nxt.payload_b6;
                    payload_b7 <= nxt.payload_b7;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result transaction against the oldest prediction
    always @(posedge clk)
    begin
        feedback_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_results++;
                if (feedback_q.size() == 0)
                begin
                    report_error("result with no frame pending");
                end
                else
                begin
                    want = feedback_q.pop_front();
                    if (left_pos !== want.left_pos)
                        report_error($sformatf("left_pos %0d, expected %0d",
                                               left_pos, want.left_pos));
                    if (right_pos !== want.right_pos)
                        report_error($sformatf("right_pos %0d, expected %0d",
                                               right_pos, want.right_pos));
                    if (left_rpm !== want.left_rpm)
                        report_error($sformatf("left_rpm %0d, expected %0d",
                                               left_rpm, want.left_rpm));
                    if (right_rpm !== want.right_rpm)
                        report_error($sformatf("right_rpm %0d, expected %0d",
                                               right_rpm, want.right_rpm));
                    if (battery_level !== want.battery)
                        report_error($sformatf("battery_level %0d, expected %0d",
                                               battery_level, want.battery));
                    if (motion_class !== want.motion)
                        report_error($sformatf("motion_class %0d, expected %0d",
                                               motion_class, want.motion));
                    if (want.motion <= MOTION_STOPPED)
                        class_seen[want.motion]++;
                end
            end
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_node_ids(input logic [ID_W-1:0] l, input logic [ID_W-1:0] r);
        logic [DATA_W-1:0] rd;
        apb_write(ADDR_LEFT_ID, DATA_W'(l));
        apb_write(ADDR_RIGHT_ID, DATA_W'(r));
        left_node = l;
        right_node = r;
        n_settings++;
        apb_read(ADDR_LEFT_ID, rd);
        if (rd[ID_W-1:0] !== l)
            report_error($sformatf("left id reads %0d, expected %0d", rd[ID_W-1:0], l));
        apb_read(ADDR_RIGHT_ID, rd);
        if (rd[ID_W-1:0] !== r)
            report_error($sformatf("right id reads %0d, expected %0d", rd[ID_W-1:0], r));
        @(negedge clk);
    endtask

    // wait until every frame is taken and every result has come back
    task automatic drain();
        while (frame_q.size() != 0 || in_valid || feedback_q.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic queue_frame(
        input logic [ID_W-1:0]   id,
        input logic [BYTE_W-1:0] kind,
        input logic [BYTE_W-1:0] idx,
        input logic [31:0]       data
    );
        frame_t f;
        f.frame_id   = id;
        f.kind_byte  = kind;
        f.index_byte = idx;
        {f.payload_b4, f.payload_b5, f.payload_b6, f.payload_b7} = data;
        frame_q.push_back(f);
    endtask

    function automatic logic [BYTE_W-1:0] rand_byte();
        logic [BYTE_W-1:0] corner[4] = '{8'h00, 8'hFF, 8'h7F, 8'h80};
        if ($urandom_range(9) == 0)
            return corner[$urandom_range(3)];
        return BYTE_W'($urandom_range(255));
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        int pick;
        logic [BYTE_W-1:0] kinds[2] = '{KIND_HEARTBEAT, KIND_STATUS};
        logic [BYTE_W-1:0] idxs[4] = '{IDX_POSITION, IDX_SPEED, IDX_VOLTAGE, 8'h00};
        f.payload_b4 = rand_byte();
        f.payload_b5 = rand_byte();
        f.payload_b6 = rand_byte();
        f.payload_b7 = rand_byte();
        f.frame_id = $urandom_range(1) ? left_node : right_node;
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            f.kind_byte  = KIND_HEARTBEAT;
            f.index_byte = IDX_POSITION;
        end
        else if (pick < 65)
        begin
            f.kind_byte  = KIND_HEARTBEAT;
            f.index_byte = IDX_SPEED;
        end
        else if (pick < 75)
        begin
            f.frame_id   = right_node;
            f.kind_byte  = KIND_STATUS;
            f.index_byte = IDX_VOLTAGE;
        end
        else if (pick < 87)
        begin
            // near miss: known node, mixed-up kind and index
            f.kind_byte  = kinds[$urandom_range(1)];
            idxs[3] = rand_byte();
            f.index_byte = idxs[$urandom_range(3)];
        end
        else
        begin
            f.frame_id   = ID_W'($urandom_range(2047));
            f.kind_byte  = rand_byte();
            f.index_byte = rand_byte();
        end
        return f;
    endfunction

    initial
    begin
        logic [ID_W-1:0] phase_left[4];
        logic [ID_W-1:0] phase_right[4];
        left_node  = LEFT_ID_RESET;
        right_node = RIGHT_ID_RESET;
        stored = '{left_pos: '0, right_pos: '0, left_rpm: '0, right_rpm: '0,
                   battery: BATTERY_RESET, motion: MOTION_STOPPED};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // unmatched frames
        queue_frame(11'd3, KIND_HEARTBEAT, IDX_POSITION, 32'h1234_5678);
        queue_frame(11'd0, KIND_HEARTBEAT, IDX_POSITION, 32'hFFFF_FFFF);
        queue_frame(11'd2047, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        // position extremes, right side wraps on negation
        queue_frame(LEFT_ID_RESET, KIND_HEARTBEAT, IDX_POSITION, 32'h8000_0000);
        queue_frame(LEFT_ID_RESET, KIND_HEARTBEAT, IDX_POSITION, 32'h7FFF_FFFF);
        queue_frame(LEFT_ID_RESET, KIND_HEARTBEAT, IDX_POSITION, 32'hFFFF_FFFF);
        queue_frame(RIGHT_ID_RESET, KIND_HEARTBEAT, IDX_POSITION, 32'h0000_0001);
        queue_frame(RIGHT_ID_RESET, KIND_HEARTBEAT, IDX_POSITION, 32'h8000_0000);
        queue_frame(RIGHT_ID_RESET, KIND_HEARTBEAT, IDX_POSITION, 32'h0000_0000);
        // unknown heartbeat index
        queue_frame(LEFT_ID_RESET, KIND_HEARTBEAT, 8'h22, 32'h0000_7FFF);
        queue_frame(RIGHT_ID_RESET, KIND_HEARTBEAT, IDX_VOLTAGE, 32'h0000_00AA);
        // speeds walk through every motion class
        queue_frame(LEFT_ID_RESET, KIND_HEARTBEAT, IDX_SPEED, 32'h0000_7FFF);
        queue_frame(RIGHT_ID_RESET, KIND_HEARTBEAT, IDX_SPEED, 32'h0000_F000);
        queue_frame(RIGHT_ID_RESET, KIND_HEARTBEAT, IDX_SPEED, 32'h0000_0003);
        queue_frame(LEFT_ID_RESET, KIND_HEARTBEAT, IDX_SPEED, 32'h0000_8000);
        queue_frame(RIGHT_ID_RESET, KIND_HEARTBEAT, IDX_SPEED, 32'h0000_8000);
        queue_frame(RIGHT_ID_RESET, KIND_HEARTBEAT, IDX_SPEED, 32'h0000_8001);
        queue_frame(LEFT_ID_RESET, KIND_HEARTBEAT, IDX_SPEED, 32'h0000_FFFF);
        queue_frame(LEFT_ID_RESET, KIND_HEARTBEAT, IDX_SPEED, 32'h0000_FFFD);
        // battery updates and ignored status replies
        queue_frame(RIGHT_ID_RESET, KIND_STATUS, IDX_VOLTAGE, 32'h0000_00FF);
        queue_frame(RIGHT_ID_RESET, KIND_STATUS, IDX_VOLTAGE, 32'hFFFF_FF00);
        queue_frame(LEFT_ID_RESET, KIND_STATUS, IDX_VOLTAGE, 32'h0000_007F);
        queue_frame(RIGHT_ID_RESET, KIND_STATUS, IDX_POSITION, 32'h0000_0055);
        queue_frame(RIGHT_ID_RESET, 8'h00, IDX_SPEED, 32'h0000_1234);
        drain();

        phase_left  = '{11'd0, 11'h555, 11'd2047, ID_W'($urandom_range(2047))};
        phase_right = '{11'd2047, 11'h555, 11'd0, ID_W'($urandom_range(2047))};
        for (int p = 0; p < 4; p++)
        begin
            set_node_ids(phase_left[p], phase_right[p]);
            for (int i = 0; i < 310; i++)
            begin
                frame_q.push_back(random_frame());
                // hold the sender once until the decoder has emptied out
                if (p == 0 && i == 150)
                    drain();
            end
            drain();
        end

        repeat (5) @(negedge clk);
        if (feedback_q.size() != 0)
            report_error($sformatf("%0d results never arrived", feedback_q.size()));
        $display("Decoded %0d frames, checked %0d results under %0d node id settings",
                 n_accepted, n_results, n_settings);
        $display("Motion classes fwd/spin-r/spin-l/back/stop: %0d/%0d/%0d/%0d/%0d",
                 class_seen[0], class_seen[1], class_seen[2], class_seen[3], class_seen[4]);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
